// ===== src/cts_pkg.sv =====
// Shared types, constants and helpers for the Cyrillic tokenizer and suffix stemmer.
`default_nettype none
package cts_pkg;

    // Depth of the letter row and letter code of U+0451
    localparam int BUF_DEPTH   = 32;
    localparam int NUM_ENDINGS = 28;
    localparam logic [5:0] YO_CODE = 6'd33;
    localparam logic [10:0] LETTER_BASE = 11'h430;

    // One character request
    typedef struct packed {
        logic [20:0] code_point;
        logic        end_of_text;
    } char_req_t;

    // One stem letter request
    typedef struct packed {
        logic [10:0] letter;
        logic        last_letter;
        logic        truncated;
    } stem_req_t;

    // Control for one letter cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Folded character: letter flag and letter code
    typedef struct packed {
        logic       is_letter;
        logic [5:0] code;
    } fold_t;

    // Ending: length, then letters in word order
    typedef struct packed {
        logic [2:0]       len;
        logic [0:3][5:0]  letters;
    } suffix_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    // Endings, tried in this order
    localparam suffix_t SUFFIX_TABLE [NUM_ENDINGS] = '{
        '{3'd4, {6'd8,  6'd31, 6'd12, 6'd8}},
        '{3'd3, {6'd31, 6'd12, 6'd8,  6'd0}},
        '{3'd3, {6'd0,  6'd12, 6'd8,  6'd0}},
        '{3'd3, {6'd8,  6'd5,  6'd9,  6'd0}},
        '{3'd2, {6'd8,  6'd9,  6'd0,  6'd0}},
        '{3'd2, {6'd27, 6'd9,  6'd0,  6'd0}},
        '{3'd2, {6'd14, 6'd9,  6'd0,  6'd0}},
        '{3'd2, {6'd8,  6'd31, 6'd0,  6'd0}},
        '{3'd2, {6'd28, 6'd31, 6'd0,  6'd0}},
        '{3'd2, {6'd8,  6'd5,  6'd0,  6'd0}},
        '{3'd2, {6'd28, 6'd5,  6'd0,  6'd0}},
        '{3'd2, {6'd27, 6'd21, 6'd0,  6'd0}},
        '{3'd2, {6'd19, 6'd30, 6'd0,  6'd0}},
        '{3'd2, {6'd30, 6'd30, 6'd0,  6'd0}},
        '{3'd2, {6'd0,  6'd31, 6'd0,  6'd0}},
        '{3'd2, {6'd31, 6'd31, 6'd0,  6'd0}},
        '{3'd2, {6'd14, 6'd12, 6'd0,  6'd0}},
        '{3'd2, {6'd5,  6'd12, 6'd0,  6'd0}},
        '{3'd2, {6'd0,  6'd21, 6'd0,  6'd0}},
        '{3'd2, {6'd31, 6'd21, 6'd0,  6'd0}},
        '{3'd1, {6'd27, 6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd8,  6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd0,  6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd31, 6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd14, 6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd5,  6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd19, 6'd0,  6'd0,  6'd0}},
        '{3'd1, {6'd30, 6'd0,  6'd0,  6'd0}}
    };

    // Fold upper case to lower case and map to a letter code
    function automatic fold_t cts_fold(input logic [20:0] cp);
        fold_t r;
        r.is_letter = 1'b1;
        r.code      = '0;
        if (cp inside {[21'h410:21'h42F]}) begin
            r.code = 6'(cp - 21'h410);
        end
        else if (cp inside {[21'h430:21'h44F]}) begin
            r.code = 6'(cp - 21'h430);
        end
        else if (cp == 21'h401 || cp == 21'h451) begin
            r.code = YO_CODE;
        end
        else begin
            r.is_letter = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/cyrillic_tokenizer_suffix_stemmer_top.sv =====
// Top level of the Cyrillic tokenizer and suffix stemmer.
// Takes one code point per char request and returns stems one letter per stem request.
// A letter is taken and written into the cell row at the current word length;
// letters past the capacity min(MAX_WORD, 32) are dropped and the stem is flagged
// truncated. A non-letter or end_of_text closes the word: the input is held in
// ST_CLOSE while the ending matcher picks the cut, then in ST_EMIT while the stem
// letters are sent from cell 0, which drives the output, as the row shifts toward
// it; stem_stall holds the row. When end_of_text rides on the last letter, that
// letter is stored and closes the word. A non-letter that closes no word is taken
// without holding the input.
`default_nettype none
module cyrillic_tokenizer_suffix_stemmer_top #(
    parameter int MAX_WORD = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire cts_pkg::char_req_t char_data,
    output logic                    stem_valid,
    input  wire logic               stem_stall,
    output cts_pkg::stem_req_t      stem_data
);
    import cts_pkg::*;

    localparam int WordCap = (MAX_WORD < BUF_DEPTH) ? MAX_WORD : BUF_DEPTH;
    localparam int CntW    = $clog2(WordCap + 1);

    state_t          state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] left_reg, left_next;
    logic            ovf_reg, ovf_next;

    logic            accept;
    logic            store;
    logic            emit_fire;
    fold_t           fold;
    logic [2:0]      cut_len;

    logic [5:0]      cell_code [WordCap];
    cell_ctl_t       cell_ctl  [WordCap];

    assign fold   = cts_fold(char_data.code_point);
    assign accept = char_valid && !char_stall;

    // Row of letter cells; cell 0 holds the next letter to send
    for (genvar g = 0; g < WordCap; g++)
    begin : g_cell
        logic [5:0] next_code;
        if (g == WordCap - 1)
        begin : g_end
            assign next_code = '0;
        end
        else
        begin : g_mid
            assign next_code = cell_code[g+1];
        end
        assign cell_ctl[g].load  = store && (count_reg == CntW'(g));
        assign cell_ctl[g].shift = emit_fire;
        cts_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[g]),
            .load_code (fold.code),
            .next_code (next_code),
            .code      (cell_code[g])
        );
    end

    // Ending matcher on the last stored letters
    cts_suffix #(
        .CntW (CntW)
    ) u_suffix (
        .clk      (clk),
        .push     (store),
        .code     (fold.code),
        .word_len (count_reg),
        .cut_len  (cut_len)
    );

    // Hold state, counters and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            left_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Collect letters, select the cut, then send the stem
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        char_stall = 1'b1;
        stem_valid = 1'b0;
        store      = 1'b0;
        emit_fire  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                char_stall = 1'b0;
                if (accept && fold.is_letter)
                begin
                    if (count_reg < CntW'(WordCap))
                    begin
                        store      = 1'b1;
                        count_next = count_reg + CntW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (accept && (!fold.is_letter || char_data.end_of_text) &&
                    (count_reg != '0 || store))
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                left_next  = count_reg - CntW'(cut_len);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                stem_valid = 1'b1;
                if (!stem_stall)
                begin
                    emit_fire = 1'b1;
                    left_next = left_reg - CntW'(1);
                    if (left_reg == CntW'(1))
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign stem_data.letter      = LETTER_BASE + {5'd0, cell_code[0]};
    assign stem_data.last_letter = (left_reg == CntW'(1));
    assign stem_data.truncated   = ovf_reg;

    // Checks on the word and stem counters, the truncation flag and request overlap
    a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> left_reg != '0 && left_reg <= count_reg)
        else $error("stem count out of range while sending");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall) |-> !stem_valid)
        else $error("char request taken while a stem letter is pending");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stem_valid && !stem_stall && stem_data.last_letter) |=>
            count_reg == '0 && !ovf_reg && state_reg == ST_COLLECT)
        else $error("word not cleared after last stem letter");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CntW'(WordCap))
        else $error("truncation flag set on a word that is not full");

    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE |-> count_reg != '0)
        else $error("closing an empty word");

endmodule
`default_nettype wire

// ===== src/cts_cell.sv =====
// One letter cell of the word row: loads a letter or takes its neighbor's letter.
`default_nettype none
module cts_cell (
    input  wire logic             clk,
    input  wire cts_pkg::cell_ctl_t ctl,
    input  wire logic [5:0]       load_code,
    input  wire logic [5:0]       next_code,
    output logic [5:0]            code
);

    logic [5:0] code_reg;

    // Load a new letter, or advance toward the head of the row
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            code_reg <= load_code;
        end
        else if (ctl.shift)
        begin
            code_reg <= next_code;
        end
    end

    assign code = code_reg;

endmodule
`default_nettype wire

// ===== src/cts_suffix.sv =====
// Tail window of the last four stored letters and the ending matcher.
`default_nettype none
module cts_suffix #(
    parameter int CntW = 6
) (
    input  wire logic            clk,
    input  wire logic            push,
    input  wire logic [5:0]      code,
    input  wire logic [CntW-1:0] word_len,
    output logic [2:0]           cut_len
);
    import cts_pkg::*;

    // tail_reg[0] is the last letter, tail_reg[3] the fourth from the end
    logic [3:0][5:0] tail_reg;

    // Shift in each stored letter
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tail_reg <= {tail_reg[2:0], code};
        end
    end

    // Pick the first ending in list order that matches and leaves at least three letters
    always_comb
    begin
        int   idx;
        logic hit;
        cut_len = '0;
        for (int i = NUM_ENDINGS - 1; i >= 0; i--)
        begin
            hit = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                idx = int'(SUFFIX_TABLE[i].len) - 1 - k;
                if (k < int'(SUFFIX_TABLE[i].len) &&
                    tail_reg[idx[1:0]] != SUFFIX_TABLE[i].letters[k])
                begin
                    hit = 1'b0;
                end
            end
            if (hit && int'(word_len) > int'(SUFFIX_TABLE[i].len) + 2)
            begin
                cut_len = SUFFIX_TABLE[i].len;
            end
        end
    end

endmodule
`default_nettype wire
